// ----- hw/rtl/u8u32_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package u8u32_pkg;

   localparam int BYTE_W = 8;
   localparam int CP_W   = 21;

   // Queue between front and back: depth must be a power of two
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam logic [BYTE_W-1:0] ASCII_MAX   = 8'h7F;
   localparam logic [BYTE_W-1:0] LEAD_MIN    = 8'hC0;
   localparam logic [BYTE_W-1:0] LEAD2_MIN   = 8'hC2;
   localparam logic [BYTE_W-1:0] LEAD2_MAX   = 8'hDF;
   localparam logic [BYTE_W-1:0] LEAD3_MIN   = 8'hE0;
   localparam logic [BYTE_W-1:0] LEAD3_MAX   = 8'hEF;
   localparam logic [BYTE_W-1:0] LEAD4_MIN   = 8'hF0;
   localparam logic [BYTE_W-1:0] LEAD4_MAX   = 8'hF4;
   localparam logic [BYTE_W-1:0] SUFFIX_MIN  = 8'h80;
   localparam logic [BYTE_W-1:0] SUFFIX_MAX  = 8'hBF;
   localparam logic [BYTE_W-1:0] LEAD_SURR   = 8'hED;
   localparam logic [BYTE_W-1:0] SUFFIX_9F   = 8'h9F;
   localparam logic [BYTE_W-1:0] SUFFIX_8F   = 8'h8F;
   localparam logic [BYTE_W-1:0] SUFFIX_90   = 8'h90;
   localparam logic [BYTE_W-1:0] SUFFIX_A0   = 8'hA0;

   typedef struct packed {
      logic is_ascii;
      logic is_lead;
      logic is_suffix;
      logic legal_lead;
      logic scope22;
      logic scope32;
      logic scope33;
      logic scope42;
      logic scope43;
      logic scope44;
      logic range_bad;
   } class_type;

   typedef struct packed {
      class_type         cls;
      logic [BYTE_W-1:0] cur;
      logic [5:0]        p1_bits;
      logic [5:0]        p2_bits;
      logic [2:0]        p3_bits;
   } entry_type;

   function automatic logic in_range(input logic [BYTE_W-1:0] b,
                                     input logic [BYTE_W-1:0] lo,
                                     input logic [BYTE_W-1:0] hi);
      return (b >= lo) && (b <= hi);
   endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/u8u32_front.sv -----
`timescale 1ns / 1ps
`default_nettype none

module u8u32_front import u8u32_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire logic [BYTE_W-1:0] data_byte,
   output entry_type              entry
);

   logic [BYTE_W-1:0] p1_ff, p2_ff, p3_ff;
   logic [BYTE_W-1:0] p1_in, p2_in, p3_in;
   class_type         cls;

   // advance the byte history on every accepted transaction
   always_comb begin
      p1_in = p1_ff;
      p2_in = p2_ff;
      p3_in = p3_ff;
      if (push) begin
         p1_in = data_byte;
         p2_in = p1_ff;
         p3_in = p2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_ff <= '0;
         p2_ff <= '0;
         p3_ff <= '0;
      end else begin
         p1_ff <= p1_in;
         p2_ff <= p2_in;
         p3_ff <= p3_in;
      end
   end

   always_comb begin
      cls.is_ascii   = data_byte <= ASCII_MAX;
      cls.is_lead    = data_byte >= LEAD_MIN;
      cls.is_suffix  = in_range(data_byte, SUFFIX_MIN, SUFFIX_MAX);
      cls.legal_lead = in_range(data_byte, LEAD2_MIN, LEAD2_MAX)
                     | in_range(data_byte, LEAD3_MIN, LEAD3_MAX)
                     | in_range(data_byte, LEAD4_MIN, LEAD4_MAX);
      cls.scope22    = in_range(p1_ff, LEAD2_MIN, LEAD2_MAX);
      cls.scope32    = in_range(p1_ff, LEAD3_MIN, LEAD3_MAX);
      cls.scope33    = in_range(p2_ff, LEAD3_MIN, LEAD3_MAX);
      cls.scope42    = in_range(p1_ff, LEAD4_MIN, LEAD4_MAX);
      cls.scope43    = in_range(p2_ff, LEAD4_MIN, LEAD4_MAX);
      cls.scope44    = in_range(p3_ff, LEAD4_MIN, LEAD4_MAX);
      // overlong, surrogate and above-U+10FFFF second bytes
      cls.range_bad  = ((p1_ff == LEAD3_MIN) && in_range(data_byte, SUFFIX_MIN, SUFFIX_9F))
                     | ((p1_ff == LEAD_SURR) && in_range(data_byte, SUFFIX_A0, SUFFIX_MAX))
                     | ((p1_ff == LEAD4_MIN) && in_range(data_byte, SUFFIX_MIN, SUFFIX_8F))
                     | ((p1_ff == LEAD4_MAX) && in_range(data_byte, SUFFIX_90, SUFFIX_MAX));
   end

   always_comb begin
      entry.cls     = cls;
      entry.cur     = data_byte;
      entry.p1_bits = p1_ff[5:0];
      entry.p2_bits = p2_ff[5:0];
      entry.p3_bits = p3_ff[2:0];
   end

endmodule

`default_nettype wire

// ----- hw/rtl/u8u32_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none

module u8u32_queue import u8u32_pkg::*; (
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      push,
   input  wire entry_type push_entry,
   input  wire logic      pop,
   output entry_type      pop_entry,
   output logic           full,
   output logic           empty
);

   entry_type              slot_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] count_ff, count_in;

   assign full      = count_ff == QUEUE_CNT_W'(QUEUE_DEPTH);
   assign empty     = count_ff == '0;
   assign pop_entry = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

`default_nettype wire

// ----- hw/rtl/u8u32_back.sv -----
`timescale 1ns / 1ps
`default_nettype none

module u8u32_back import u8u32_pkg::*; (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            queue_empty,
   input  wire entry_type       entry,
   output logic                 pop,
   output logic                 rsp_valid,
   input  wire logic            rsp_stall,
   output logic [CP_W-1:0]      rsp_code_point,
   output logic                 rsp_delete_mark,
   output logic                 rsp_error_mark
);

   logic            valid_ff, valid_in;
   logic [CP_W-1:0] cp_ff, cp_in;
   logic            del_ff, del_in;
   logic            err_ff, err_in;
   logic            any_scope;

   // refill the output register when it is empty or being taken
   assign pop      = !queue_empty && (!valid_ff || !rsp_stall);
   assign valid_in = pop || (valid_ff && rsp_stall);

   always_comb begin
      cp_in = '0;
      if (entry.cls.is_ascii) begin
         cp_in = cp_in | {14'b0, entry.cur[6:0]};
      end
      if (entry.cls.scope22) begin
         cp_in = cp_in | {10'b0, entry.p1_bits[4:0], entry.cur[5:0]};
      end
      if (entry.cls.scope33) begin
         cp_in = cp_in | {5'b0, entry.p2_bits[3:0], entry.p1_bits, entry.cur[5:0]};
      end
      if (entry.cls.scope44) begin
         cp_in = cp_in | {entry.p3_bits, entry.p2_bits, entry.p1_bits, entry.cur[5:0]};
      end

      any_scope = entry.cls.scope22 | entry.cls.scope32 | entry.cls.scope33
                | entry.cls.scope42 | entry.cls.scope43 | entry.cls.scope44;
      err_in    = (entry.cls.is_lead != entry.cls.legal_lead)
                | (any_scope != entry.cls.is_suffix)
                | entry.cls.range_bad;
      del_in    = entry.cls.is_lead | entry.cls.scope32
                | entry.cls.scope42 | entry.cls.scope43;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         cp_ff  <= cp_in;
         del_ff <= del_in;
         err_ff <= err_in;
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_code_point  = cp_ff;
   assign rsp_delete_mark = del_ff;
   assign rsp_error_mark  = err_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/utf8_to_utf32_stream_decoder.sv -----
// Path: an accepted byte is classified into a queue slot, then decoded into the output register.
// Throughput: one byte per clock unless a side stalls; the two-entry queue between
// the classifier and the output stage lets either side stall without a bubble.
// Reset: synchronous, active high; clears the three-byte history to zero
// and empties the queue and the output register.
`timescale 1ns / 1ps
`default_nettype none

module utf8_to_utf32_stream_decoder import u8u32_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire logic [BYTE_W-1:0] req_data_byte,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output logic [CP_W-1:0]        rsp_code_point,
   output logic                   rsp_delete_mark,
   output logic                   rsp_error_mark
);

   entry_type push_entry;
   entry_type pop_entry;
   logic      push;
   logic      pop;
   logic      queue_full;
   logic      queue_empty;

   assign req_stall = queue_full;
   assign push      = req_valid && !queue_full;

   u8u32_front u_front (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .data_byte (req_data_byte),
      .entry     (push_entry)
   );

   u8u32_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .pop_entry  (pop_entry),
      .full       (queue_full),
      .empty      (queue_empty)
   );

   u8u32_back u_back (
      .clock           (clock),
      .reset           (reset),
      .queue_empty     (queue_empty),
      .entry           (pop_entry),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_code_point  (rsp_code_point),
      .rsp_delete_mark (rsp_delete_mark),
      .rsp_error_mark  (rsp_error_mark)
   );

endmodule

`default_nettype wire

// ----- test/utf8_to_utf32_stream_decoder_test.sv -----
`timescale 1ns / 1ps

module utf8_to_utf32_stream_decoder_test;
   import u8u32_pkg::*;

   typedef struct packed {
      logic [CP_W-1:0] code_point;
      logic            delete_mark;
      logic            error_mark;
   } utf32_result_type;

   localparam int PHASE_BYTES = 275;

   localparam logic [BYTE_W-1:0] OPENING_BYTES [25] = '{
      8'h00, ASCII_MAX, SUFFIX_MIN, LEAD_MIN, 8'hC1, LEAD2_MIN, SUFFIX_MIN, LEAD2_MAX,
      8'h41, LEAD3_MIN, SUFFIX_9F, SUFFIX_MAX, LEAD_SURR, SUFFIX_A0, SUFFIX_MIN,
      LEAD4_MIN, SUFFIX_8F, SUFFIX_MIN, SUFFIX_MIN, LEAD4_MAX, SUFFIX_90, SUFFIX_MAX,
      SUFFIX_MAX, 8'hF5, 8'hFF
   };

   localparam logic [BYTE_W-1:0] BOUNDARY_BYTES [10] = '{
      LEAD_MIN, 8'hC1, 8'hF5, 8'hFF, SUFFIX_MIN, SUFFIX_MAX, LEAD3_MIN, LEAD_SURR,
      LEAD4_MIN, LEAD4_MAX
   };

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   logic [BYTE_W-1:0] req_data_byte = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic [CP_W-1:0]   rsp_code_point;
   logic              rsp_delete_mark;
   logic              rsp_error_mark;

   logic [BYTE_W-1:0] byte_feed [$];
   utf32_result_type  decoded_due [$];
   utf32_result_type  oldest_due;
   logic [BYTE_W-1:0] recent_bytes [3];

   int sender_idle_pct = 36;
   int receiver_idle_pct = 78;
   bit sender_hold = 1'b0;
   bit failed = 1'b0;

   utf8_to_utf32_stream_decoder dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_data_byte   (req_data_byte),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_code_point  (rsp_code_point),
      .rsp_delete_mark (rsp_delete_mark),
      .rsp_error_mark  (rsp_error_mark)
   );

   always #6 clock = ~clock;

   // Decode one byte against the three bytes before it, then shift it into the history.
   function automatic utf32_result_type decode_byte(input logic [BYTE_W-1:0] cur);
      logic [BYTE_W-1:0] p1, p2, p3;
      logic in22, in32, in33, in42, in43, in44;
      logic suffix, lead, legal, overrange;
      utf32_result_type r;
      p1 = recent_bytes[0];
      p2 = recent_bytes[1];
      p3 = recent_bytes[2];
      in22 = p1 >= LEAD2_MIN && p1 <= LEAD2_MAX;
      in32 = p1 >= LEAD3_MIN && p1 <= LEAD3_MAX;
      in33 = p2 >= LEAD3_MIN && p2 <= LEAD3_MAX;
      in42 = p1 >= LEAD4_MIN && p1 <= LEAD4_MAX;
      in43 = p2 >= LEAD4_MIN && p2 <= LEAD4_MAX;
      in44 = p3 >= LEAD4_MIN && p3 <= LEAD4_MAX;
      suffix = cur >= SUFFIX_MIN && cur <= SUFFIX_MAX;
      lead = cur >= LEAD_MIN;
      legal = (cur >= LEAD2_MIN && cur <= LEAD2_MAX) || (cur >= LEAD3_MIN && cur <= LEAD3_MAX)
              || (cur >= LEAD4_MIN && cur <= LEAD4_MAX);
      overrange = (p1 == LEAD3_MIN && cur >= SUFFIX_MIN && cur <= SUFFIX_9F)
                  || (p1 == LEAD_SURR && cur >= SUFFIX_A0 && cur <= SUFFIX_MAX)
                  || (p1 == LEAD4_MIN && cur >= SUFFIX_MIN && cur <= SUFFIX_8F)
                  || (p1 == LEAD4_MAX && cur >= SUFFIX_90 && cur <= SUFFIX_MAX);
      // overlapping scopes simply OR together
      r.code_point = '0;
      if (cur <= ASCII_MAX) r.code_point |= CP_W'(cur[6:0]);
      if (in22) r.code_point |= CP_W'({p1[4:0], cur[5:0]});
      if (in33) r.code_point |= CP_W'({p2[3:0], p1[5:0], cur[5:0]});
      if (in44) r.code_point |= CP_W'({p3[2:0], p2[5:0], p1[5:0], cur[5:0]});
      r.delete_mark = lead || in32 || in42 || in43;
      r.error_mark = (lead != legal) || ((in22 || in32 || in33 || in42 || in43 || in44) != suffix)
                     || overrange;
      recent_bytes[2] = p2;
      recent_bytes[1] = p1;
      recent_bytes[0] = cur;
      return r;
   endfunction

   function automatic logic [BYTE_W-1:0] any_suffix();
      return BYTE_W'($urandom_range(SUFFIX_MAX, SUFFIX_MIN));
   endfunction

   function automatic logic [BYTE_W-1:0] lead_of_length(input int n);
      case (n)
         2: return BYTE_W'($urandom_range(LEAD2_MAX, LEAD2_MIN));
         3: return BYTE_W'($urandom_range(LEAD3_MAX, LEAD3_MIN));
         default: return BYTE_W'($urandom_range(LEAD4_MAX, LEAD4_MIN));
      endcase
   endfunction

   // Queue one character: mostly well-formed, the rest noise and cut-off sequences.
   task automatic queue_random_char();
      int pick;
      int n;
      logic [BYTE_W-1:0] lead;
      pick = $urandom_range(99);
      if (pick < 25) begin
         byte_feed.push_back(BYTE_W'($urandom_range(ASCII_MAX)));
      end else if (pick < 75) begin
         n = (pick < 42) ? 2 : (pick < 60) ? 3 : 4;
         lead = lead_of_length(n);
         byte_feed.push_back(lead);
         if (lead == LEAD3_MIN) begin
            byte_feed.push_back(BYTE_W'($urandom_range(SUFFIX_MAX, SUFFIX_A0)));
         end else if (lead == LEAD_SURR) begin
            byte_feed.push_back(BYTE_W'($urandom_range(SUFFIX_9F, SUFFIX_MIN)));
         end else if (lead == LEAD4_MIN) begin
            byte_feed.push_back(BYTE_W'($urandom_range(SUFFIX_MAX, SUFFIX_90)));
         end else if (lead == LEAD4_MAX) begin
            byte_feed.push_back(BYTE_W'($urandom_range(SUFFIX_8F, SUFFIX_MIN)));
         end else begin
            byte_feed.push_back(any_suffix());
         end
         for (int i = 2; i < n; i++) byte_feed.push_back(any_suffix());
      end else if (pick < 85) begin
         byte_feed.push_back(BYTE_W'($urandom_range(255)));
      end else if (pick < 93) begin
         n = $urandom_range(4, 2);
         byte_feed.push_back(lead_of_length(n));
         repeat ($urandom_range(n - 2)) byte_feed.push_back(any_suffix());
      end else begin
         byte_feed.push_back(BOUNDARY_BYTES[$urandom_range(9)]);
      end
   endtask

   task automatic queue_random_bytes(input int count);
      int target;
      target = byte_feed.size() + count;
      while (byte_feed.size() < target) queue_random_char();
   endtask

   task automatic wait_drained();
      do @(negedge clock);
      while (byte_feed.size() != 0 || req_valid || decoded_due.size() != 0);
   endtask

   // driver: hold the payload while stalled, otherwise offer the next byte or idle
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || !req_stall) begin
         if (byte_feed.size() != 0 && !sender_hold && $urandom_range(99) >= sender_idle_pct) begin
            req_valid <= 1'b1;
            req_data_byte <= byte_feed.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // monitor: predict on each accepted byte, then check each accepted result
   always @(posedge clock) begin
      if (reset) begin
         recent_bytes = '{default: '0};
         rsp_stall <= 1'b0;
      end else begin
         if (req_valid && !req_stall) decoded_due.push_back(decode_byte(req_data_byte));
         if (rsp_valid && !rsp_stall) begin
            if (decoded_due.size() == 0) begin
               $display("%0t: unexpected transaction, code_point %0h", $time, rsp_code_point);
               failed = 1'b1;
            end else begin
               oldest_due = decoded_due.pop_front();
               if (rsp_code_point !== oldest_due.code_point) begin
                  $display("%0t: code_point expected %0h actual %0h", $time,
                           oldest_due.code_point, rsp_code_point);
                  failed = 1'b1;
               end
               if (rsp_delete_mark !== oldest_due.delete_mark) begin
                  $display("%0t: delete_mark expected %0b actual %0b", $time,
                           oldest_due.delete_mark, rsp_delete_mark);
                  failed = 1'b1;
               end
               if (rsp_error_mark !== oldest_due.error_mark) begin
                  $display("%0t: error_mark expected %0b actual %0b", $time,
                           oldest_due.error_mark, rsp_error_mark);
                  failed = 1'b1;
               end
            end
         end
         rsp_stall <= ($urandom_range(99) < receiver_idle_pct);
      end
   end

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      foreach (OPENING_BYTES[i]) byte_feed.push_back(OPENING_BYTES[i]);
      queue_random_bytes(PHASE_BYTES);
      wait_drained();

      sender_idle_pct = 78;
      receiver_idle_pct = 36;
      queue_random_bytes(PHASE_BYTES / 2);
      // hold the sender until the decoder has emptied, then carry on
      do @(negedge clock);
      while (byte_feed.size() > PHASE_BYTES / 4);
      sender_hold = 1'b1;
      do @(negedge clock);
      while (req_valid || decoded_due.size() != 0);
      sender_hold = 1'b0;
      queue_random_bytes(PHASE_BYTES - PHASE_BYTES / 2);
      wait_drained();

      sender_idle_pct = 0;
      receiver_idle_pct = 0;
      queue_random_bytes(PHASE_BYTES);
      wait_drained();

      repeat (6) @(negedge clock);
      if (!failed && decoded_due.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("Some tests failed");
      $finish;
   end

endmodule
